// ----- design/rcg_pkg.sv -----
`default_nettype none

package rcg_pkg;

    // datapath widths
    localparam int DIV_BITS  = 36;             // dividend width of the shared divider
    localparam int CNT_W     = 6;              // divider iteration counter
    localparam int PC_W      = 5;
    localparam int OP_W      = 5;
    localparam int COND_W    = 3;

    localparam logic [16:0] PHASE_ONE    = 17'd65536;
    localparam logic [24:0] MIN_STEP_US  = 25'd100000;
    localparam logic [24:0] STEP_MAX     = 25'h1FF_FFFF;
    localparam logic [24:0] STEP_RESET   = 25'd1000000;
    localparam logic [23:0] BASE_RESET   = 24'd1000000;
    localparam logic [16:0] FADE_RESET   = 17'd32768;
    localparam logic [16:0] VAR_RESET    = 17'd32768;

    // register indexes
    localparam logic [1:0] CFG_STEP_TIME = 2'd0;
    localparam logic [1:0] CFG_FADE      = 2'd1;
    localparam logic [1:0] CFG_VARIATION = 2'd2;

    // datapath operations
    localparam logic [OP_W-1:0] OP_NOP      = 5'd0;
    localparam logic [OP_W-1:0] OP_LATCH    = 5'd1;
    localparam logic [OP_W-1:0] OP_EFF_MUL  = 5'd2;
    localparam logic [OP_W-1:0] OP_EFF_SEL  = 5'd3;
    localparam logic [OP_W-1:0] OP_DIV_PROG = 5'd4;
    localparam logic [OP_W-1:0] OP_DIV_STEP = 5'd5;
    localparam logic [OP_W-1:0] OP_SUM      = 5'd6;
    localparam logic [OP_W-1:0] OP_NUM_MUL  = 5'd7;
    localparam logic [OP_W-1:0] OP_NUM_ADD  = 5'd8;
    localparam logic [OP_W-1:0] OP_RD_LO    = 5'd9;
    localparam logic [OP_W-1:0] OP_RD_HI    = 5'd10;
    localparam logic [OP_W-1:0] OP_RD_SUM   = 5'd11;
    localparam logic [OP_W-1:0] OP_HOLD     = 5'd12;
    localparam logic [OP_W-1:0] OP_FADE_A   = 5'd13;
    localparam logic [OP_W-1:0] OP_FADE_B   = 5'd14;
    localparam logic [OP_W-1:0] OP_DIV_FADE = 5'd15;
    localparam logic [OP_W-1:0] OP_QUOT     = 5'd16;
    localparam logic [OP_W-1:0] OP_EMIT     = 5'd17;
    localparam logic [OP_W-1:0] OP_SYNC     = 5'd18;

    // jump conditions
    localparam logic [COND_W-1:0] C_NONE        = 3'd0;
    localparam logic [COND_W-1:0] C_NO_IN       = 3'd1;
    localparam logic [COND_W-1:0] C_REQ         = 3'd2;
    localparam logic [COND_W-1:0] C_SZERO       = 3'd3;
    localparam logic [COND_W-1:0] C_DIV_MORE    = 3'd4;
    localparam logic [COND_W-1:0] C_NO_WRAP     = 3'd5;
    localparam logic [COND_W-1:0] C_FADE_HOLD   = 3'd6;
    localparam logic [COND_W-1:0] C_OUT_BLOCKED = 3'd7;

    // program addresses
    localparam logic [PC_W-1:0] S_IDLE    = 5'd0;
    localparam logic [PC_W-1:0] S_EFF_MUL = 5'd1;
    localparam logic [PC_W-1:0] S_EFF_SEL = 5'd2;
    localparam logic [PC_W-1:0] S_DIV1_LD = 5'd3;
    localparam logic [PC_W-1:0] S_DIV1    = 5'd4;
    localparam logic [PC_W-1:0] S_SUM     = 5'd5;
    localparam logic [PC_W-1:0] S_NUM_MUL = 5'd6;
    localparam logic [PC_W-1:0] S_NUM_ADD = 5'd7;
    localparam logic [PC_W-1:0] S_RD_LO   = 5'd8;
    localparam logic [PC_W-1:0] S_RD_HI   = 5'd9;
    localparam logic [PC_W-1:0] S_RD_SUM  = 5'd10;
    localparam logic [PC_W-1:0] S_OUT     = 5'd11;
    localparam logic [PC_W-1:0] S_FADE_A  = 5'd12;
    localparam logic [PC_W-1:0] S_FADE_B  = 5'd13;
    localparam logic [PC_W-1:0] S_DIV2_LD = 5'd14;
    localparam logic [PC_W-1:0] S_DIV2    = 5'd15;
    localparam logic [PC_W-1:0] S_QUOT    = 5'd16;
    localparam logic [PC_W-1:0] S_EMIT    = 5'd17;
    localparam logic [PC_W-1:0] S_SYNC    = 5'd18;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
        logic              fin;     // fall through to idle instead of pc+1
    } cw_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            idle;
    } ctrl_t;

    typedef struct packed {
        logic req;
        logic s_zero;
        logic div_more;
        logic no_wrap;
        logic fade_hold;
        logic out_blocked;
    } stat_t;

    function automatic cw_t mk(input logic [OP_W-1:0] op, input logic [COND_W-1:0] cond,
                               input logic [PC_W-1:0] target, input logic fin);
        cw_t w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        w.fin    = fin;
        return w;
    endfunction

    // microprogram
    function automatic cw_t rom(input logic [PC_W-1:0] pc);
        cw_t w;
        unique case (pc)
            S_IDLE:    w = mk(OP_LATCH,    C_NO_IN,       S_IDLE,   1'b0);
            S_EFF_MUL: w = mk(OP_EFF_MUL,  C_REQ,         S_SYNC,   1'b0);
            S_EFF_SEL: w = mk(OP_EFF_SEL,  C_NONE,        S_IDLE,   1'b0);
            S_DIV1_LD: w = mk(OP_DIV_PROG, C_SZERO,       S_IDLE,   1'b0);
            S_DIV1:    w = mk(OP_DIV_STEP, C_DIV_MORE,    S_DIV1,   1'b0);
            S_SUM:     w = mk(OP_SUM,      C_NO_WRAP,     S_OUT,    1'b0);
            S_NUM_MUL: w = mk(OP_NUM_MUL,  C_NONE,        S_IDLE,   1'b0);
            S_NUM_ADD: w = mk(OP_NUM_ADD,  C_NONE,        S_IDLE,   1'b0);
            S_RD_LO:   w = mk(OP_RD_LO,    C_NONE,        S_IDLE,   1'b0);
            S_RD_HI:   w = mk(OP_RD_HI,    C_NONE,        S_IDLE,   1'b0);
            S_RD_SUM:  w = mk(OP_RD_SUM,   C_NONE,        S_IDLE,   1'b0);
            S_OUT:     w = mk(OP_HOLD,     C_FADE_HOLD,   S_EMIT,   1'b0);
            S_FADE_A:  w = mk(OP_FADE_A,   C_NONE,        S_IDLE,   1'b0);
            S_FADE_B:  w = mk(OP_FADE_B,   C_NONE,        S_IDLE,   1'b0);
            S_DIV2_LD: w = mk(OP_DIV_FADE, C_NONE,        S_IDLE,   1'b0);
            S_DIV2:    w = mk(OP_DIV_STEP, C_DIV_MORE,    S_DIV2,   1'b0);
            S_QUOT:    w = mk(OP_QUOT,     C_NONE,        S_IDLE,   1'b0);
            S_EMIT:    w = mk(OP_EMIT,     C_OUT_BLOCKED, S_EMIT,   1'b1);
            S_SYNC:    w = mk(OP_SYNC,     C_NONE,        S_IDLE,   1'b1);
            default:   w = mk(OP_NOP,      C_NONE,        S_IDLE,   1'b1);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- design/rcg_seq.sv -----
`default_nettype none

module rcg_seq (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    input  wire rcg_pkg::stat_t stat,
    output rcg_pkg::ctrl_t      ctrl
);

    logic [rcg_pkg::PC_W-1:0] pc_reg;
    logic [rcg_pkg::PC_W-1:0] pc_next;
    rcg_pkg::cw_t             cw;
    logic                     take;

    always_comb begin
        cw = rcg_pkg::rom(pc_reg);
        unique case (cw.cond)
            rcg_pkg::C_NONE:        take = 1'b0;
            rcg_pkg::C_NO_IN:       take = !s_valid;
            rcg_pkg::C_REQ:         take = stat.req;
            rcg_pkg::C_SZERO:       take = stat.s_zero;
            rcg_pkg::C_DIV_MORE:    take = stat.div_more;
            rcg_pkg::C_NO_WRAP:     take = stat.no_wrap;
            rcg_pkg::C_FADE_HOLD:   take = stat.fade_hold;
            rcg_pkg::C_OUT_BLOCKED: take = stat.out_blocked;
            default:                take = 1'b0;
        endcase
        if (take) begin
            pc_next = cw.target;
        end else if (cw.fin) begin
            pc_next = rcg_pkg::S_IDLE;
        end else begin
            pc_next = pc_reg + 1'b1;
        end
        ctrl.op   = cw.op;
        ctrl.idle = (pc_reg == rcg_pkg::S_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= rcg_pkg::S_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/rcg_dp.sv -----
`default_nettype none

module rcg_dp (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire rcg_pkg::ctrl_t ctrl,
    output rcg_pkg::stat_t      stat,
    input  wire logic           cfg_valid,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [23:0]    cfg_data,
    input  wire logic           s_req_type,
    input  wire logic [19:0]    s_elapsed_us,
    input  wire logic [15:0]    s_rand_target,
    input  wire logic [15:0]    s_rand_time,
    input  wire logic           s_mod_enable,
    input  wire logic [15:0]    s_mod_value,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [15:0]         m_current_value
);

    localparam int DB = rcg_pkg::DIV_BITS;

    // configuration
    logic [23:0] st_reg;
    logic [16:0] fr_reg;
    logic [16:0] tv_reg;

    // generator state
    logic [16:0] phase_reg;
    logic [15:0] old_reg;
    logic [15:0] new_reg;
    logic [24:0] step_reg;

    // latched word
    logic        req_reg;
    logic [19:0] el_reg;
    logic [15:0] rt_reg;
    logic [15:0] rtime_reg;
    logic        men_reg;
    logic [15:0] mval_reg;

    // work registers
    logic [24:0]   s_reg;
    logic [42:0]   mul_reg;
    logic [42:0]   acc_reg;
    logic [34:0]   num_reg;
    logic [DB-1:0] quo_reg;
    logic [24:0]   rem_reg;
    logic [24:0]   dvs_reg;
    logic [rcg_pkg::CNT_W-1:0] cnt_reg;
    logic [15:0]   val_reg;
    logic          m_valid_reg;
    logic [15:0]   m_data_reg;

    logic [24:0] mul_a;
    logic [17:0] mul_b;
    logic [42:0] prod;
    logic [16:0] fr_minus_ph;
    logic [36:0] sum;
    logic        wrap;
    logic [34:0] num_calc;
    logic [42:0] rd_sum;
    logic [26:0] rd_v;
    logic [25:0] rem_sh;
    logic [25:0] rem_sub;
    logic        rem_ge;
    logic [DB-1:0] fade_sum;
    logic        out_blocked;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.op)
            rcg_pkg::OP_EFF_MUL: begin
                mul_a = step_reg;
                mul_b = {2'b0, mval_reg};
            end
            rcg_pkg::OP_NUM_MUL: begin
                mul_a = {8'd0, tv_reg};
                mul_b = {1'b0, rtime_reg, 1'b0};
            end
            rcg_pkg::OP_RD_LO: begin
                mul_a = {1'b0, st_reg};
                mul_b = {2'b0, num_reg[15:0]};
            end
            rcg_pkg::OP_RD_HI: begin
                mul_a = {1'b0, st_reg};
                mul_b = num_reg[33:16];
            end
            rcg_pkg::OP_FADE_A: begin
                mul_a = {9'd0, old_reg};
                mul_b = {1'b0, fr_minus_ph};
            end
            rcg_pkg::OP_FADE_B: begin
                mul_a = {9'd0, new_reg};
                mul_b = {1'b0, phase_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod        = mul_a * mul_b;
    assign fr_minus_ph = fr_reg - phase_reg;
    assign sum         = {20'd0, phase_reg} + {1'b0, quo_reg};
    assign wrap        = (sum > {20'd0, rcg_pkg::PHASE_ONE});
    // 2^32 + tv*2r - tv*2^16; bit 34 flags a negative scale
    assign num_calc    = 35'h1_0000_0000 + {1'b0, mul_reg[33:0]} - {2'd0, tv_reg, 16'd0};
    assign rd_sum      = mul_reg + acc_reg;
    assign rd_v        = rd_sum[42:16];
    assign rem_sh      = {rem_reg, quo_reg[DB-1]};
    assign rem_ge      = (rem_sh >= {1'b0, dvs_reg});
    assign rem_sub     = rem_sh - {1'b0, dvs_reg};
    assign fade_sum    = acc_reg[DB-1:0] + mul_reg[DB-1:0];
    assign out_blocked = m_valid_reg && !m_ready;

    always_comb begin
        stat.req         = req_reg;
        stat.s_zero      = (s_reg == 25'd0);
        stat.div_more    = (cnt_reg != rcg_pkg::CNT_W'(DB - 1));
        stat.no_wrap     = !wrap;
        stat.fade_hold   = (fr_reg == 17'd0) || (phase_reg >= fr_reg);
        stat.out_blocked = out_blocked;
    end

    // state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= rcg_pkg::BASE_RESET;
            fr_reg      <= rcg_pkg::FADE_RESET;
            tv_reg      <= rcg_pkg::VAR_RESET;
            phase_reg   <= '0;
            old_reg     <= '0;
            new_reg     <= '0;
            step_reg    <= rcg_pkg::STEP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    rcg_pkg::CFG_STEP_TIME: st_reg <= cfg_data;
                    rcg_pkg::CFG_FADE:      fr_reg <= cfg_data[16:0];
                    rcg_pkg::CFG_VARIATION: tv_reg <= cfg_data[16:0];
                    default: ;
                endcase
            end
            if (ctrl.op == rcg_pkg::OP_EMIT && !out_blocked) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (ctrl.op)
                rcg_pkg::OP_SUM: begin
                    phase_reg <= {1'b0, sum[15:0]};
                    if (wrap) begin
                        old_reg <= new_reg;
                        new_reg <= rt_reg;
                    end
                end
                rcg_pkg::OP_RD_SUM: begin
                    if (num_reg[34] || rd_v == 27'd0) begin
                        step_reg <= rcg_pkg::MIN_STEP_US;
                    end else if (rd_v > {2'b0, rcg_pkg::STEP_MAX}) begin
                        step_reg <= rcg_pkg::STEP_MAX;
                    end else begin
                        step_reg <= rd_v[24:0];
                    end
                end
                rcg_pkg::OP_SYNC: phase_reg <= rcg_pkg::PHASE_ONE;
                default: ;
            endcase
        end
    end

    // work registers, no reset
    always_ff @(posedge aclk) begin
        case (ctrl.op)
            rcg_pkg::OP_LATCH: begin
                req_reg   <= s_req_type;
                el_reg    <= s_elapsed_us;
                rt_reg    <= s_rand_target;
                rtime_reg <= s_rand_time;
                men_reg   <= s_mod_enable;
                mval_reg  <= s_mod_value;
            end
            rcg_pkg::OP_EFF_MUL: mul_reg <= prod;
            rcg_pkg::OP_EFF_SEL: s_reg   <= men_reg ? mul_reg[40:16] : step_reg;
            rcg_pkg::OP_DIV_PROG: begin
                quo_reg <= {el_reg, 16'd0};
                rem_reg <= '0;
                dvs_reg <= s_reg;
                cnt_reg <= '0;
            end
            rcg_pkg::OP_DIV_STEP: begin
                rem_reg <= rem_ge ? rem_sub[24:0] : rem_sh[24:0];
                quo_reg <= {quo_reg[DB-2:0], rem_ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
            rcg_pkg::OP_NUM_MUL: mul_reg  <= prod;
            rcg_pkg::OP_NUM_ADD: num_reg  <= num_calc;
            rcg_pkg::OP_RD_LO:   mul_reg  <= prod;
            rcg_pkg::OP_RD_HI: begin
                acc_reg <= {19'd0, mul_reg[39:16]};
                mul_reg <= prod;
            end
            rcg_pkg::OP_HOLD:    val_reg <= new_reg;
            rcg_pkg::OP_FADE_A:  mul_reg <= prod;
            rcg_pkg::OP_FADE_B: begin
                acc_reg <= mul_reg;
                mul_reg <= prod;
            end
            rcg_pkg::OP_DIV_FADE: begin
                quo_reg <= fade_sum;
                rem_reg <= '0;
                dvs_reg <= {8'd0, fr_reg};
                cnt_reg <= '0;
            end
            rcg_pkg::OP_QUOT: val_reg <= quo_reg[15:0];
            rcg_pkg::OP_EMIT: begin
                if (!out_blocked) begin
                    m_data_reg <= val_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_current_value = m_data_reg;

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= rcg_pkg::PHASE_ONE)
        else $error("phase beyond one");

    a_step_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg != 25'd0)
        else $error("step time is zero");

    a_sum_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.op == rcg_pkg::OP_SUM |=> phase_reg < rcg_pkg::PHASE_ONE)
        else $error("phase not reduced after advance");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.op == rcg_pkg::OP_DIV_STEP |-> cnt_reg < rcg_pkg::CNT_W'(DB))
        else $error("divider overran");

    a_fade_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.op == rcg_pkg::OP_QUOT |-> quo_reg[DB-1:16] == '0)
        else $error("crossfade quotient exceeds 16 bits");

endmodule

`default_nettype wire

// ----- design/random_crossfade_generator.sv -----
// Channel  | Direction | Handshake           | Word
// ---------+-----------+---------------------+-------------------------------------------
// cfg      | in        | cfg_valid/cfg_ready | cfg_index (0 step, 1 fade, 2 variation), cfg_data
// s_       | in        | s_valid/s_ready     | req_type, elapsed_us, rand_target, rand_time,
//          |           |                     | mod_enable, mod_value
// m_       | out       | m_valid/m_ready     | current_value
//
// A frame tick makes one divider pass, a second when it fades, and a wrap adds the step
//   redraw; a sync word and a tick with a zero effective step skip the radix-2 divider.
// One word at a time: s_ready is high only while the sequencer sits at its idle step.
// The result register frees the input side: a new word is taken while a result waits,
//   and the sequencer stalls at its emit step only if the previous one is still held.
// Reset (aresetn low, synchronous) restores the register defaults and generator state.
// cfg_ready is always high; writes belong to idle periods.
`default_nettype none

module random_crossfade_generator (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_type,
    input  wire logic [19:0] s_elapsed_us,
    input  wire logic [15:0] s_rand_target,
    input  wire logic [15:0] s_rand_time,
    input  wire logic        s_mod_enable,
    input  wire logic [15:0] s_mod_value,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_current_value
);

    rcg_pkg::ctrl_t ctrl;   // control word from the microprogram
    rcg_pkg::stat_t stat;   // flags that steer its jumps

    // sequencer: step counter, program table, jump logic
    rcg_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    // datapath: shared 25x18 multiplier, restoring divider, state and result register
    rcg_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl            (ctrl),
        .stat            (stat),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_req_type      (s_req_type),
        .s_elapsed_us    (s_elapsed_us),
        .s_rand_target   (s_rand_target),
        .s_rand_time     (s_rand_time),
        .s_mod_enable    (s_mod_enable),
        .s_mod_value     (s_mod_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_current_value (m_current_value)
    );

    // input taken only at the idle step, where the word is latched
    assign s_ready   = ctrl.idle;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ----- verif/random_crossfade_generator_test.sv -----
`timescale 1ns / 100ps

module random_crossfade_generator_test;

    // tb-local codes
    typedef enum logic {
        REQ_TICK = 1'b0,
        REQ_SYNC = 1'b1
    } req_e;

    localparam logic [1:0] CFG_UNUSED = 2'd3;   // no register behind this index

    localparam int DRAIN_CYCLES = 200;   // > worst tick latency with margin
    localparam int STALL_LIMIT  = 4000;  // cycles with no handshake on any channel
    localparam int SINK_HOLD    = 300;   // long m_ready hold-off for back-pressure
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        req_e        req;
        logic [19:0] elapsed;
        logic [15:0] rtarget;
        logic [15:0] rtime;
        logic        men;
        logic [15:0] mval;
    } frame_word_t;

    typedef struct packed {
        frame_word_t w;
        logic        typed;   // level below is known by hand
        logic [15:0] level;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;

    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;

    logic        s_valid;
    logic        s_ready;
    logic        s_req_type;
    logic [19:0] s_elapsed_us;
    logic [15:0] s_rand_target;
    logic [15:0] s_rand_time;
    logic        s_mod_enable;
    logic [15:0] s_mod_value;

    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_current_value;

    // travels with the word: hand-typed expectation for directed rows
    logic        typed_valid;
    logic [15:0] typed_level;

    // generator state as the block should hold it
    logic [23:0] base_step   = rcg_pkg::BASE_RESET;
    logic [16:0] fade_share  = rcg_pkg::FADE_RESET;
    logic [16:0] step_spread = rcg_pkg::VAR_RESET;
    logic [16:0] phase_acc   = '0;
    logic [15:0] level_from  = '0;
    logic [15:0] level_to    = '0;
    logic [24:0] step_now    = rcg_pkg::STEP_RESET;

    logic [15:0] level_q[$];   // levels still owed by the block

    int  fault_count = 0;
    int  stall_count = 0;
    int  sink_hold   = 0;      // set by the sequence, served by the sink process
    bit  no_idle     = 1'b0;   // neither side idles
    bit  sender_eager = 1'b0;  // sender never idles

    random_crossfade_generator dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_elapsed_us    (s_elapsed_us),
        .s_rand_target   (s_rand_target),
        .s_rand_time     (s_rand_time),
        .s_mod_enable    (s_mod_enable),
        .s_mod_value     (s_mod_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_current_value (m_current_value)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Step redraw: base * (1 + spread*(2r-1)), done on the 2^32 scale.
    // Non-positive scale or a zero result falls back to the minimum step;
    // anything past 25 bits saturates.
    // ------------------------------------------------------------------
    function automatic logic [24:0] redraw_step_us(input logic [15:0] r);
        longint      dev;
        longint      scale;
        logic [63:0] v;
        dev   = longint'({r, 1'b0}) - 65536;
        scale = (longint'(1) <<< 32) + longint'(step_spread) * dev;
        if (scale <= 0)
            return rcg_pkg::MIN_STEP_US;
        v = (64'(base_step) * 64'(scale)) >> 32;
        if (v == 64'd0)
            return rcg_pkg::MIN_STEP_US;
        if (v > 64'(rcg_pkg::STEP_MAX))
            return rcg_pkg::STEP_MAX;
        return v[24:0];
    endfunction

    // ------------------------------------------------------------------
    // One word into the generator. Returns 1 when a level comes out.
    // Sync parks the phase at 1.0 so the next tick wraps unless its
    // progress is zero (landing exactly on 1.0 is not a wrap).
    // ------------------------------------------------------------------
    function automatic logic advance_generator(input frame_word_t w,
                                               output logic [15:0] level);
        logic [40:0] eff;
        logic [63:0] sum;
        logic [63:0] acc;
        level = '0;
        if (w.req == REQ_SYNC) begin
            phase_acc = rcg_pkg::PHASE_ONE;
            return 1'b0;
        end
        eff = 41'(step_now);
        if (w.men)
            eff = (eff * 41'(w.mval)) >> 16;
        if (eff == '0)
            return 1'b0;                  // zero effective step: word ignored
        sum = 64'(phase_acc) + ((64'(w.elapsed) << 16) / 64'(eff));
        if (sum > 64'(rcg_pkg::PHASE_ONE)) begin
            level_from = level_to;
            level_to   = w.rtarget;
            step_now   = redraw_step_us(w.rtime);
        end
        phase_acc = 17'(sum[15:0]);
        // fade from old to new over the first fade_share of the step
        if (fade_share != '0 && phase_acc < fade_share) begin
            acc = 64'(level_from) * 64'(fade_share - phase_acc)
                + 64'(level_to) * 64'(phase_acc);
            level = 16'(acc / 64'(fade_share));
        end else begin
            level = level_to;
        end
        return 1'b1;
    endfunction

    // Idle stretch length: mostly short, now and then long.
    function automatic int idle_span();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(1, 3);
        if (pick < 95)
            return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    // Mostly ticks whose elapsed time is sized against the live step so
    // wraps, exact landings and slow crawls all show up; some syncs, some
    // modulated words (zero-step ones among them), some raw noise.
    function automatic frame_word_t random_frame_word();
        frame_word_t w;
        int unsigned span;
        int unsigned pick;
        w.req     = ($urandom_range(0, 99) < 8) ? REQ_SYNC : REQ_TICK;
        w.rtarget = 16'($urandom);
        w.rtime   = 16'($urandom);
        w.men     = ($urandom_range(0, 4) == 0);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            w.mval = '0;
        else if (pick == 1)
            w.mval = 16'($urandom_range(1, 8));
        else
            w.mval = 16'($urandom);
        span = (step_now > 25'd1048575) ? 1048575 : int'(step_now);
        pick = $urandom_range(0, 99);
        if (pick < 40)
            w.elapsed = 20'($urandom_range(0, span / 4));
        else if (pick < 60)
            w.elapsed = 20'($urandom_range(0, (span > 524287) ? 1048575 : 2 * span));
        else if (pick < 75)
            w.elapsed = 20'($urandom);
        else if (pick < 85)
            w.elapsed = '0;
        else if (pick < 95)
            w.elapsed = 20'(span);        // one full step from phase 0
        else
            w.elapsed = 20'hFFFFF;
        return w;
    endfunction

    function automatic dir_row_t row(input req_e req, input logic [19:0] e,
                                     input logic [15:0] tgt, input logic [15:0] rt,
                                     input logic men, input logic [15:0] mv,
                                     input logic typed, input logic [15:0] lvl);
        dir_row_t d;
        d.w.req     = req;
        d.w.elapsed = e;
        d.w.rtarget = tgt;
        d.w.rtime   = rt;
        d.w.men     = men;
        d.w.mval    = mv;
        d.typed     = typed;
        d.level     = lvl;
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Input driver. Called right at an edge; leaves s_valid high after the
    // handshake so a back-to-back word needs only one assignment per step.
    // ------------------------------------------------------------------
    task automatic offer_word(input frame_word_t w, input logic typed,
                              input logic [15:0] lvl);
        int gap;
        gap = 0;
        if (!no_idle && !sender_eager && $urandom_range(0, 2) == 0)
            gap = idle_span();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= w.req;
        s_elapsed_us  <= w.elapsed;
        s_rand_target <= w.rtarget;
        s_rand_time   <= w.rtime;
        s_mod_enable  <= w.men;
        s_mod_value   <= w.mval;
        typed_valid   <= typed;
        typed_level   <= lvl;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Wait out every owed level, then the block's own tail (a sync or a
    // zero-step word may still be in flight with nothing owed).
    task automatic drain();
        while (level_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [23:0] step, input logic [16:0] fade,
                             input logic [16:0] spread, input int count, input int hold);
        drain();
        write_reg(rcg_pkg::CFG_STEP_TIME, step);
        write_reg(rcg_pkg::CFG_FADE, 24'(fade));
        write_reg(rcg_pkg::CFG_VARIATION, 24'(spread));
        write_reg(CFG_UNUSED, 24'($urandom));   // must be dropped
        sink_hold = hold;
        repeat (count) offer_word(random_frame_word(), 1'b0, '0);
        s_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sink: random m_ready gaps, plus a long hold-off when asked. During the
    // hold the result register fills, the sequencer parks at emit and
    // s_ready drops while the sender keeps offering.
    // ------------------------------------------------------------------
    initial begin
        int n;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (sink_hold > 0) begin
                n = sink_hold;
                sink_hold = 0;
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else if (!no_idle && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat (idle_span()) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // Predict on every accepted word, check every accepted level against
    // the oldest one owed. Check runs first so a level leaving on the same
    // edge a word enters is matched to older work.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : level_check
        frame_word_t w;
        logic [15:0] lvl;
        logic [15:0] want;
        if (!aresetn) begin
            base_step   = rcg_pkg::BASE_RESET;
            fade_share  = rcg_pkg::FADE_RESET;
            step_spread = rcg_pkg::VAR_RESET;
            phase_acc   = '0;
            level_from  = '0;
            level_to    = '0;
            step_now    = rcg_pkg::STEP_RESET;
            level_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (level_q.size() == 0) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("%0t: level %0d with none owed", $realtime, m_current_value);
                end else begin
                    want = level_q.pop_front();
                    if (m_current_value !== want) begin
                        fault_count++;
                        if (fault_count <= MAX_REPORTS)
                            $display("%0t: level expected %0d got %0d", $realtime,
                                     want, m_current_value);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    rcg_pkg::CFG_STEP_TIME: base_step   = cfg_data;
                    rcg_pkg::CFG_FADE:      fade_share  = cfg_data[16:0];
                    rcg_pkg::CFG_VARIATION: step_spread = cfg_data[16:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                w.req     = req_e'(s_req_type);
                w.elapsed = s_elapsed_us;
                w.rtarget = s_rand_target;
                w.rtime   = s_rand_time;
                w.men     = s_mod_enable;
                w.mval    = s_mod_value;
                if (advance_generator(w, lvl))
                    level_q.push_back(typed_valid ? typed_level : lvl);
            end
        end
    end

    // Watchdog: any handshake clears it.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
    end

    initial begin
        while (stall_count < STALL_LIMIT) @(posedge aclk);
        $display("random_crossfade_generator_test NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        dir_row_t    dir_rows[$];
        logic [23:0] rnd_step;
        int          k;

        aresetn       <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= rcg_pkg::CFG_STEP_TIME;
        cfg_data      <= '0;
        s_valid       <= 1'b0;
        s_req_type    <= REQ_TICK;
        s_elapsed_us  <= '0;
        s_rand_target <= '0;
        s_rand_time   <= '0;
        s_mod_enable  <= 1'b0;
        s_mod_value   <= '0;
        typed_valid   <= 1'b0;
        typed_level   <= '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, on reset settings (step 1e6 us, fade and spread one half).
        // first tick after reset: no progress, both targets zero
        dir_rows.push_back(row(REQ_TICK, 20'd0, 16'hFFFF, 16'hFFFF, 1'b0, 16'hFFFF,
                               1'b1, 16'd0));
        // sync then zero progress: lands exactly on 1.0, no wrap
        dir_rows.push_back(row(REQ_SYNC, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF,
                               1'b0, '0));
        dir_rows.push_back(row(REQ_TICK, 20'd0, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0,
                               1'b1, 16'd0));
        // sync then one tick of progress: wrap, top target, longest redraw
        dir_rows.push_back(row(REQ_SYNC, 20'd0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0, '0));
        dir_rows.push_back(row(REQ_TICK, 20'd20, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0,
                               1'b0, '0));
        // longest elapsed time
        dir_rows.push_back(row(REQ_TICK, 20'hFFFFF, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0, '0));
        // modulation zero: effective step zero, word ignored
        dir_rows.push_back(row(REQ_TICK, 20'd5000, 16'h1234, 16'h4321, 1'b1, 16'd0,
                               1'b0, '0));
        // smallest nonzero modulation
        dir_rows.push_back(row(REQ_TICK, 20'd0, 16'h0F0F, 16'hF0F0, 1'b1, 16'd1, 1'b0, '0));
        dir_rows.push_back(row(REQ_TICK, 20'hAAAAA, 16'h5555, 16'hAAAA, 1'b1, 16'hFFFF,
                               1'b0, '0));
        dir_rows.push_back(row(REQ_TICK, 20'h55555, 16'hAAAA, 16'h5555, 1'b0, 16'h5555,
                               1'b0, '0));
        // sync held through an ignored tick, then a wrap with the shortest redraw
        dir_rows.push_back(row(REQ_SYNC, 20'd0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0, '0));
        dir_rows.push_back(row(REQ_TICK, 20'd0, 16'hFFFF, 16'hFFFF, 1'b1, 16'd0, 1'b0, '0));
        dir_rows.push_back(row(REQ_TICK, 20'hFFFFF, 16'h8000, 16'd0, 1'b0, 16'd0,
                               1'b0, '0));
        dir_rows.push_back(row(REQ_TICK, 20'd0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0, '0));
        dir_rows.push_back(row(REQ_TICK, 20'd100000, 16'd1, 16'h8000, 1'b0, 16'd0,
                               1'b0, '0));
        foreach (dir_rows[i])
            offer_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].level);
        s_valid <= 1'b0;

        // short base step, full-step fade, no spread: frequent wraps
        run_phase(24'd1000, 17'd65536, 17'd0, 130, 0);
        // zero base (every redraw floors), thinnest fade, full spread
        run_phase(24'd0, 17'd1, 17'd65536, 100, 0);
        // largest base, no fade, widest spread (scale goes negative or saturates)
        no_idle = 1'b1;
        run_phase(24'hFFFFFF, 17'd0, 17'h1FFFF, 100, 0);
        no_idle = 1'b0;
        // back-pressure: sink holds off while the sender keeps pushing
        sender_eager = 1'b1;
        run_phase(24'd2000, 17'h1FFFF, 17'd65536, 120, SINK_HOLD);
        sender_eager = 1'b0;
        // a long base step, then random settings
        run_phase(24'd10000000, 17'd40000, 17'd6554, 60, 0);
        for (k = 0; k < 4; k++) begin
            case ($urandom_range(0, 2))
                0:       rnd_step = 24'($urandom_range(0, 3000));
                1:       rnd_step = 24'($urandom_range(0, 2000000));
                default: rnd_step = 24'($urandom);
            endcase
            run_phase(rnd_step, 17'($urandom), 17'($urandom), 80, 0);
        end

        drain();
        if (fault_count == 0)
            $display("random_crossfade_generator_test OK");
        else
            $display("random_crossfade_generator_test NOT OK");
        $finish;
    end

endmodule
